### hw/rtl/binary_to_decimal_ascii_defines.svh
// Assertion macros shared by the binary-to-decimal ASCII RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// expr must hold at every edge outside reset
`define B2DA_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold at the same edge as ante
`define B2DA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// cons must hold at the edge after ante
`define B2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/b2da_pkg.sv
// Types, constants and the double-dabble step for the decimal ASCII converter.
// No dependencies.
package b2da_pkg;

	localparam int WORD_W    = 32;
	localparam int NDIGITS   = 10;
	localparam int BCD_W     = 4 * NDIGITS;
	localparam int DD_STEPS  = 8;   // shift/add-3 steps per pipeline stage
	localparam int BYTE_DIGS = 3;
	localparam int CNT_W     = 4;

	// format codes
	localparam logic [1:0] FMT_U32 = 2'd0;
	localparam logic [1:0] FMT_S32 = 2'd1;
	localparam logic [1:0] FMT_U8  = 2'd2;

	localparam logic [CNT_W-1:0] CNT_U32 = CNT_W'(NDIGITS);
	localparam logic [CNT_W-1:0] CNT_S32 = CNT_W'(NDIGITS + 1);
	localparam logic [CNT_W-1:0] CNT_U8  = CNT_W'(BYTE_DIGS);

	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_MINUS = 8'h2D;
	localparam logic [7:0] CHR_SPACE = 8'h20;

	typedef struct packed {
		logic [1:0]        op;
		logic [WORD_W-1:0] value;
	} num_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} chr_t;

	// word in flight through the conversion pipeline
	typedef struct packed {
		logic [1:0]        fmt;
		logic              neg;
		logic [BCD_W-1:0]  bcd;
		logic [WORD_W-1:0] bin;
	} dd_t;

	// finished digits handed to the serialiser
	typedef struct packed {
		logic [1:0]       fmt;
		logic             neg;
		logic [BCD_W-1:0] bcd;
	} dig_t;

	// DD_STEPS rounds of add-3 then shift left
	function automatic dd_t b2da_dabble(input dd_t d);
		logic [BCD_W+WORD_W-1:0] w;
		dd_t r;
		w = {d.bcd, d.bin};
		for (int i = 0; i < DD_STEPS; i++) begin
			for (int n = 0; n < NDIGITS; n++) begin
				if (w[WORD_W+4*n +: 4] >= 4'd5) begin
					w[WORD_W+4*n +: 4] = w[WORD_W+4*n +: 4] + 4'd3;
				end
			end
			w = {w[BCD_W+WORD_W-2:0], 1'b0};
		end
		r     = d;
		r.bcd = w[BCD_W+WORD_W-1:WORD_W];
		r.bin = w[WORD_W-1:0];
		return r;
	endfunction

endpackage

### hw/rtl/b2da_serialiser.sv
// Character serialiser: turns one set of BCD digits into a run of ASCII characters.
// Depends on b2da_pkg and binary_to_decimal_ascii_defines.svh.
`include "binary_to_decimal_ascii_defines.svh"

module b2da_serialiser import b2da_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic dig_valid,
	output logic dig_ready,
	input  dig_t dig,
	output logic chr_valid,
	input  logic chr_ready,
	output chr_t chr
);

	logic [CNT_W-1:0] cnt_q;      // characters still to emit
	logic             sign_pend_q;
	logic             neg_q;
	logic [BCD_W-1:0] digits_q;   // left aligned, next digit on top
	logic             chr_valid_q;
	chr_t             chr_q;
	logic             out_free;
	logic             load;
	chr_t             next_chr;

	assign out_free  = !chr_valid_q || chr_ready;
	assign dig_ready = (cnt_q == '0) || (out_free && cnt_q == CNT_W'(1));
	assign load      = dig_valid && dig_ready;

	always_comb begin
		next_chr.last = (cnt_q == CNT_W'(1));
		if (sign_pend_q) begin
			next_chr.char_code = neg_q ? CHR_MINUS : CHR_SPACE;
		end else begin
			next_chr.char_code = CHR_ZERO + {4'd0, digits_q[BCD_W-1 -: 4]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			sign_pend_q <= 1'b0;
			chr_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				if (cnt_q != '0) begin
					chr_valid_q <= 1'b1;
					cnt_q       <= cnt_q - CNT_W'(1);
					if (sign_pend_q) begin
						sign_pend_q <= 1'b0;
					end
				end else begin
					chr_valid_q <= 1'b0;
				end
			end
			if (load) begin
				case (dig.fmt)
					FMT_U32: begin
						cnt_q       <= CNT_U32;
						sign_pend_q <= 1'b0;
					end
					FMT_S32: begin
						cnt_q       <= CNT_S32;
						sign_pend_q <= 1'b1;
					end
					default: begin
						cnt_q       <= CNT_U8;
						sign_pend_q <= 1'b0;
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (out_free && cnt_q != '0) begin
			chr_q <= next_chr;
			if (!sign_pend_q) begin
				digits_q <= {digits_q[BCD_W-5:0], 4'd0};
			end
		end
		if (load) begin
			neg_q <= dig.neg;
			if (dig.fmt == FMT_U32 || dig.fmt == FMT_S32) begin
				digits_q <= dig.bcd;
			end else begin
				digits_q <= {dig.bcd[4*BYTE_DIGS-1:0], (BCD_W - 4*BYTE_DIGS)'(0)};
			end
		end
	end

	assign chr_valid = chr_valid_q;
	assign chr       = chr_q;

	`B2DA_ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q <= CNT_S32, "character count out of range")
	`B2DA_ASSERT_SAME(a_sign_first, clk, arst_n, sign_pend_q, cnt_q == CNT_S32, "sign pending mid-run")
	`B2DA_ASSERT_NEXT(a_last_flag, clk, arst_n, out_free && cnt_q == CNT_W'(1), chr_valid_q && chr_q.last, "final character not flagged")
	`B2DA_ASSERT_NEXT(a_no_last_early, clk, arst_n, out_free && cnt_q > CNT_W'(1), chr_valid_q && !chr_q.last, "early last flag")

endmodule

### hw/rtl/binary_to_decimal_ascii.sv
// Top level of the binary to fixed-width decimal ASCII converter.
// Depends on b2da_pkg, b2da_serialiser and binary_to_decimal_ascii_defines.svh.
`include "binary_to_decimal_ascii_defines.svh"

// A number transaction (op, value) comes out as a run of ASCII character
// transactions, most significant first, leading zeros kept, last flagged on
// the final one: op 0 gives 10 digits, op 1 gives a sign (space or '-') and
// 10 digits of the magnitude (0x80000000 prints as -2147483648), op 2 or 3
// gives 3 digits of the low byte. The number side is a five-stage pipeline:
// stage 1 decodes the format and forms the magnitude, stages 2 to 5 each do
// eight shift/add-3 rounds of the binary to BCD conversion. Behind it the
// serialiser sends one character per cycle while chr_ready is high, via
// a registered output. A number gives 3, 10 or 11 characters; the next
// number is taken as the last character of the previous one is sent, so
// its first character follows with no gap. A number passes stages 1 to 5,
// the serialiser's digit and output registers. Back-pressure on chr_ready
// stalls the whole pipeline stage by stage; nothing is lost or repeated.

module binary_to_decimal_ascii import b2da_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic num_valid,
	output logic num_ready,
	input  num_t num,
	output logic chr_valid,
	input  logic chr_ready,
	output chr_t chr
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	dd_t  dd_s1, dd_s2, dd_s3, dd_s4, dd_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic ser_ready;
	dig_t dig;
	dd_t  dec;

	// a stage may load when it is empty or its contents move on this cycle
	assign rdy5      = !v_s5 || ser_ready;
	assign rdy4      = !v_s4 || rdy5;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign num_ready = rdy1;

	// format decode and magnitude; op bit 1 selects the byte format
	always_comb begin
		dec.bcd = '0;
		dec.neg = 1'b0;
		if (num.op[1]) begin
			dec.fmt = FMT_U8;
			dec.bin = {(WORD_W - 8)'(0), num.value[7:0]};
		end else if (num.op[0]) begin
			dec.fmt = FMT_S32;
			dec.neg = num.value[WORD_W-1];
			// two's complement negation; the most negative word maps to itself,
			// which read unsigned is the right magnitude
			dec.bin = num.value[WORD_W-1] ? (~num.value + WORD_W'(1)) : num.value;
		end else begin
			dec.fmt = FMT_U32;
			dec.bin = num.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= num_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// payload: eight dabble rounds in each of stages 2 to 5, 32 in all
	always_ff @(posedge clk) begin
		if (rdy1 && num_valid) dd_s1 <= dec;
		if (rdy2 && v_s1)      dd_s2 <= b2da_dabble(dd_s1);
		if (rdy3 && v_s2)      dd_s3 <= b2da_dabble(dd_s2);
		if (rdy4 && v_s3)      dd_s4 <= b2da_dabble(dd_s3);
		if (rdy5 && v_s4)      dd_s5 <= b2da_dabble(dd_s4);
	end

	assign dig.fmt = dd_s5.fmt;
	assign dig.neg = dd_s5.neg;
	assign dig.bcd = dd_s5.bcd;

	b2da_serialiser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.dig_valid (v_s5),
		.dig_ready (ser_ready),
		.dig       (dig),
		.chr_valid (chr_valid),
		.chr_ready (chr_ready),
		.chr       (chr)
	);

	// an accepted number always lands in stage 1
	`B2DA_ASSERT_NEXT(a_enter_s1, clk, arst_n, num_valid && num_ready, v_s1, "accepted number not captured")
	// a full stage 5 that cannot move keeps its item
	`B2DA_ASSERT_NEXT(a_hold_s5, clk, arst_n, v_s5 && !ser_ready, v_s5 && $stable(dd_s5), "stage 5 item lost in stall")
	// stage 5 only ever holds a legal format
	`B2DA_ASSERT_SAME(a_fmt_s5, clk, arst_n, v_s5, dd_s5.fmt == FMT_U32 || dd_s5.fmt == FMT_S32 || dd_s5.fmt == FMT_U8, "bad format code in pipeline")

endmodule

### test/tb_binary_to_decimal_ascii.sv
// Self-checking testbench for binary_to_decimal_ascii: number transactions in,
// ASCII character transactions out, checked against a local decimal text predictor.
// Depends on b2da_pkg and the binary_to_decimal_ascii RTL.
module tb_binary_to_decimal_ascii import b2da_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// op 3 has no format of its own; bit 1 set makes it a byte conversion
	localparam logic [1:0] FMT_SPARE = 2'd3;

	localparam int CLK_HALF    = 10;
	localparam int RESET_CYC   = 12;
	localparam int RANDOM_NUMS = 260;
	localparam int TAIL_CYC    = 24;     // drain margin for the pipeline and serialiser
	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic num_valid;
	logic num_ready;
	num_t num;
	logic chr_valid;
	logic chr_ready;
	chr_t chr;

	int tx_idle_pct;
	int rx_idle_pct;
	int cycle_count;

	// Scoreboard: turns each accepted number into the characters it must
	// produce, and matches the character transactions against them in order.
	class decimal_text_scoreboard;
		chr_t pending_chars[$];
		int   mismatches;
		int   numbers_noted;
		int   chars_checked;

		function new();
			mismatches    = 0;
			numbers_noted = 0;
			chars_checked = 0;
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		// Fixed-width decimal text, most significant character first.
		function void note_number(num_t n);
			logic [31:0] mag;
			logic [7:0]  text [11];
			int          lead;
			int          ndig;
			int          count;
			chr_t        c;
			lead = 0;
			if (n.op[1]) begin
				// byte format (also the spare code): low byte only
				mag  = {24'd0, n.value[7:0]};
				ndig = BYTE_DIGS;
			end else if (n.op == FMT_S32) begin
				// sign column, then magnitude; 0x80000000 negates to itself,
				// which is exactly the unsigned magnitude 2147483648
				lead    = 1;
				text[0] = n.value[31] ? CHR_MINUS : CHR_SPACE;
				mag     = n.value[31] ? (~n.value + 32'd1) : n.value;
				ndig    = NDIGITS;
			end else begin
				mag  = n.value;
				ndig = NDIGITS;
			end
			for (int k = ndig - 1; k >= 0; k--) begin
				text[lead + k] = CHR_ZERO + 8'(mag % 32'd10);
				mag            = mag / 32'd10;
			end
			count = lead + ndig;
			for (int k = 0; k < count; k++) begin
				c.char_code = text[k];
				c.last      = (k == count - 1);
				pending_chars.push_back(c);
			end
			numbers_noted++;
		endfunction

		task check_char(chr_t got);
			chr_t want;
			chars_checked++;
			if (pending_chars.size() == 0) begin
				report($sformatf("unexpected character 0x%02h last=%b",
					got.char_code, got.last));
			end else begin
				want = pending_chars.pop_front();
				if (got.char_code !== want.char_code)
					report($sformatf("char_code got 0x%02h want 0x%02h",
						got.char_code, want.char_code));
				if (got.last !== want.last)
					report($sformatf("last got %b want %b (char 0x%02h)",
						got.last, want.last, want.char_code));
			end
		endtask
	endclass

	decimal_text_scoreboard sb;

	binary_to_decimal_ascii u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.num_valid(num_valid),
		.num_ready(num_ready),
		.num      (num),
		.chr_valid(chr_valid),
		.chr_ready(chr_ready),
		.chr      (chr)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d characters outstanding",
					cycle_count, sb.pending_chars.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Receiver: ready changes on the falling edge, stalling at the current rate.
	initial begin
		chr_ready = 1'b0;
		forever begin
			@(negedge clk);
			chr_ready = ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Character transactions are taken at the rising edge, where both
	// valid and ready are settled from the previous falling edge.
	always @(posedge clk) begin
		if (arst_n && chr_valid && chr_ready)
			sb.check_char(chr);
	end

	// Offer one number, idling first at the current rate. Called just after
	// a rising edge; returns at the edge where the transaction is taken.
	task send_number(logic [1:0] op, logic [31:0] value);
		num_t n;
		n.op    = op;
		n.value = value;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			num_valid = 1'b0;
			@(negedge clk);
		end
		num       = n;
		num_valid = 1'b1;
		do @(posedge clk); while (!num_ready);
		sb.note_number(n);
	endtask

	// Hold the sender off until every character owed has been taken.
	task wait_drained();
		@(negedge clk);
		num_valid = 1'b0;
		while (sb.pending_chars.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
	endtask

	// Values that stress the conversion: full range, small numbers, decade
	// boundaries, the sign boundary, the top of the range and low bytes of 0 or 255.
	function automatic logic [31:0] pick_value();
		logic [31:0] p;
		int          e;
		p = 32'd1;
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(999);
			2: begin
				e = $urandom_range(9);
				for (int i = 0; i < e; i++)
					p = p * 32'd10;
				return p - $urandom_range(1);
			end
			3: return 32'h8000_0000 ^ 32'($urandom_range(3)) ^ {1'($urandom_range(1)), 31'd0};
			4: return {8'($urandom_range(255)), 8'h00, 8'h00, 8'(($urandom_range(1)) ? 255 : 0)};
			default: return 32'hFFFF_FFFF - $urandom_range(300);
		endcase
	endfunction

	initial begin
		sb          = new();
		arst_n      = 1'b0;
		num_valid   = 1'b0;
		num         = '0;
		tx_idle_pct = 38;
		rx_idle_pct = 81;

		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed: range extremes, sign boundary, zero, decade edges,
		// byte format ignoring the upper bits, and the spare selector.
		send_number(FMT_U32, 32'd0);
		send_number(FMT_U32, 32'hFFFF_FFFF);
		send_number(FMT_U32, 32'd999_999_999);
		send_number(FMT_U32, 32'd1_000_000_000);
		send_number(FMT_U32, 32'd1);
		send_number(FMT_S32, 32'd0);
		send_number(FMT_S32, 32'h8000_0000);
		send_number(FMT_S32, 32'h7FFF_FFFF);
		send_number(FMT_S32, 32'hFFFF_FFFF);
		send_number(FMT_S32, 32'h8000_0001);
		send_number(FMT_S32, 32'd1);
		send_number(FMT_U8, 32'd0);
		send_number(FMT_U8, 32'd255);
		send_number(FMT_U8, 32'hFFFF_FF00);
		send_number(FMT_U8, 32'h1234_56FF);
		send_number(FMT_U8, 32'd100);
		send_number(FMT_U8, 32'd99);
		send_number(FMT_SPARE, 32'd0);
		send_number(FMT_SPARE, 32'hFFFF_FFFF);
		send_number(FMT_SPARE, 32'hABCD_EF42);
		wait_drained();

		// Random, in three idling regimes; each ends fully drained, and
		// the odd mid-phase drain lets the pipeline run dry and refill.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin tx_idle_pct = 38; rx_idle_pct = 81; end
				1: begin tx_idle_pct = 81; rx_idle_pct = 38; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			for (int i = 0; i < RANDOM_NUMS / 3; i++) begin
				send_number(2'($urandom_range(3)), pick_value());
				if ($urandom_range(49) == 0)
					wait_drained();
			end
			wait_drained();
		end

		$display("checked %0d numbers, %0d characters, across three stall regimes",
			sb.numbers_noted, sb.chars_checked);
		$display("formats: unsigned, signed, byte and spare selector; %0d mismatches",
			sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_chars.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/b2da_pkg.sv
hw/rtl/b2da_serialiser.sv
hw/rtl/binary_to_decimal_ascii.sv
test/tb_binary_to_decimal_ascii.sv
